// File: src/dtw_pkg.sv
package dtw_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int PER_SLOT_DEF = 16;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [3:0] JITTER_SPAN_RST = 4'd8;

  typedef enum logic {
    OP_REG  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHECK,
    B_READ,
    B_SEND
  } back_state_t;

  typedef struct packed {
    logic [7:0]         sound;
    logic signed [15:0] volume;
    logic signed [15:0] pan;
    logic [15:0]        rate;
    logic [15:0]        source;
  } event_t;

  localparam int EVENT_W = $bits(event_t);

endpackage

// File: src/delayed_event_timing_wheel.sv
// Timing wheel for sound-play events.
// Input channel (in_valid/in_ready): operation 0 registers an event that is
// placed req_delay + 1 + jitter frames ahead (at most SLOTS-1); operation 1 is
// a frame tick that advances the wheel and plays out the new current slot.
// Output channel (out_valid/out_ready): one transaction per event played, in
// the order registered, with last set on the final one of a tick. A tick on
// an empty slot gives no transaction. Events for a full slot are dropped.
// cfg_we/cfg_data write jitter_span; write it only while the block is idle.
// The front takes one transaction per cycle into a four-entry command queue
// and stalls only when that queue is full. The back serves one command at a
// time: a registration passes B_IDLE and B_CHECK, a tick those and then
// B_READ and B_SEND per event, with the fill count and events read through
// registers. A tick's first event is valid after B_IDLE, B_CHECK and B_READ.
// A stalled receiver holds the current event on the outputs; the queue keeps
// filling behind it. Reset (rst, synchronous) empties every slot at once,
// clears the current slot and jitter, and sets jitter_span to 8.
module delayed_event_timing_wheel
  import dtw_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int PER_SLOT = PER_SLOT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [7:0]         sound_id,
  input  logic signed [15:0] volume,
  input  logic signed [15:0] pan,
  input  logic [15:0]        freq_rate,
  input  logic [5:0]         req_delay,
  input  logic [15:0]        source_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_sound,
  output logic signed [15:0] out_volume,
  output logic signed [15:0] out_pan,
  output logic [15:0]        out_rate,
  output logic [15:0]        out_source,
  output logic               last
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CMD_W  = 1 + SLOT_W + EVENT_W;

  logic              push;
  logic              q_full;
  op_t               push_op;
  logic [SLOT_W-1:0] push_slot;
  event_t            push_ev;
  logic              pop;
  logic              q_empty;
  logic [CMD_W-1:0]  head;
  op_t               head_op;
  logic [SLOT_W-1:0] head_slot;
  event_t            head_ev;

  dtw_front #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .sound_id  (sound_id),
    .volume    (volume),
    .pan       (pan),
    .freq_rate (freq_rate),
    .req_delay (req_delay),
    .source_id (source_id),
    .q_full    (q_full),
    .q_push    (push),
    .q_op      (push_op),
    .q_slot    (push_slot),
    .q_ev      (push_ev)
  );

  dtw_queue #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_op, push_slot, push_ev}),
    .full  (q_full),
    .pop   (pop),
    .rdata (head),
    .empty (q_empty)
  );

  assign head_op   = op_t'(head[CMD_W-1]);
  assign head_slot = head[CMD_W-2 -: SLOT_W];
  assign head_ev   = event_t'(head[EVENT_W-1:0]);

  dtw_back #(
    .SLOTS    (SLOTS),
    .PER_SLOT (PER_SLOT),
    .SLOT_W   (SLOT_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_op       (head_op),
    .q_slot     (head_slot),
    .q_ev       (head_ev),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sound  (out_sound),
    .out_volume (out_volume),
    .out_pan    (out_pan),
    .out_rate   (out_rate),
    .out_source (out_source),
    .last       (last)
  );

endmodule

// File: src/dtw_front.sv
module dtw_front
  import dtw_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int SLOT_W = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [7:0]        sound_id,
  input  logic signed [15:0] volume,
  input  logic signed [15:0] pan,
  input  logic [15:0]       freq_rate,
  input  logic [5:0]        req_delay,
  input  logic [15:0]       source_id,
  input  logic              q_full,
  output logic              q_push,
  output op_t               q_op,
  output logic [SLOT_W-1:0] q_slot,
  output event_t            q_ev
);

  logic [SLOT_W-1:0] current_slot;
  logic [SLOT_W-1:0] current_slot_next;
  logic [3:0]        jitter_count;
  logic [3:0]        jitter_count_next;
  logic [3:0]        jitter_span;
  logic [8:0]        delay_sum;
  logic [SLOT_W-1:0] delay;
  logic [SLOT_W:0]   target_sum;
  logic [SLOT_W-1:0] target;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    delay_sum = {3'b0, req_delay} + 9'd1 + {5'b0, jitter_count};
    if (delay_sum > 9'(SLOTS - 1)) begin
      delay = SLOT_W'(SLOTS - 1);
    end else begin
      delay = SLOT_W'(delay_sum);
    end
    target_sum = {1'b0, current_slot} + {1'b0, delay};
    if (target_sum >= (SLOT_W + 1)'(SLOTS)) begin
      target = SLOT_W'(target_sum - (SLOT_W + 1)'(SLOTS));
    end else begin
      target = target_sum[SLOT_W-1:0];
    end

    if (current_slot == SLOT_W'(SLOTS - 1)) begin
      current_slot_next = '0;
    end else begin
      current_slot_next = current_slot + SLOT_W'(1);
    end

    if (jitter_count >= jitter_span) begin
      jitter_count_next = 4'd0;
    end else begin
      jitter_count_next = jitter_count + 4'd1;
    end
  end

  always_comb begin
    q_op          = op_t'(operation);
    q_ev.sound    = sound_id;
    q_ev.volume   = volume;
    q_ev.pan      = pan;
    q_ev.rate     = freq_rate;
    q_ev.source   = source_id;
    if (q_op == OP_TICK) begin
      q_slot = current_slot_next;
    end else begin
      q_slot = target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_slot <= '0;
      jitter_count <= 4'd0;
      jitter_span  <= JITTER_SPAN_RST;
    end else begin
      if (cfg_we) begin
        jitter_span <= cfg_data;
      end
      if (q_push) begin
        if (q_op == OP_TICK) begin
          current_slot <= current_slot_next;
          jitter_count <= 4'd0;
        end else begin
          jitter_count <= jitter_count_next;
        end
      end
    end
  end

endmodule

// File: src/dtw_queue.sv
module dtw_queue
  import dtw_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/dtw_back.sv
module dtw_back
  import dtw_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int PER_SLOT = PER_SLOT_DEF,
  parameter int SLOT_W   = $clog2(SLOTS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  op_t                q_op,
  input  logic [SLOT_W-1:0]  q_slot,
  input  event_t             q_ev,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_sound,
  output logic signed [15:0] out_volume,
  output logic signed [15:0] out_pan,
  output logic [15:0]        out_rate,
  output logic [15:0]        out_source,
  output logic               last
);

  localparam int FILL_W = $clog2(PER_SLOT + 1);
  localparam int DEPTH  = SLOTS * PER_SLOT;
  localparam int ADDR_W = $clog2(DEPTH);

  back_state_t state;
  back_state_t state_next;

  logic [FILL_W-1:0] fill_mem [SLOTS];
  event_t            ev_mem   [DEPTH];
  logic [SLOTS-1:0]  fill_valid;

  op_t               cmd_op;
  logic [SLOT_W-1:0] cmd_slot;
  event_t            cmd_ev;
  logic [FILL_W-1:0] fill_rd;
  logic              fill_hit;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] count;
  logic [FILL_W-1:0] count_next;
  logic [FILL_W-1:0] idx;
  logic [FILL_W-1:0] idx_next;
  logic              last_next;
  event_t            ev_rd;

  logic              fill_we;
  logic              fill_clr;
  logic              ev_we;
  logic              ev_re;
  logic [ADDR_W-1:0] ev_waddr;
  logic [ADDR_W-1:0] ev_raddr;

  assign fill     = fill_hit ? fill_rd : '0;
  assign ev_waddr = ADDR_W'(cmd_slot) * ADDR_W'(PER_SLOT) + ADDR_W'(fill);
  assign ev_raddr = ADDR_W'(cmd_slot) * ADDR_W'(PER_SLOT) + ADDR_W'(idx);

  assign out_sound  = ev_rd.sound;
  assign out_volume = ev_rd.volume;
  assign out_pan    = ev_rd.pan;
  assign out_rate   = ev_rd.rate;
  assign out_source = ev_rd.source;

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    fill_we    = 1'b0;
    fill_clr   = 1'b0;
    ev_we      = 1'b0;
    ev_re      = 1'b0;
    out_valid  = 1'b0;
    count_next = count;
    idx_next   = idx;
    last_next  = (({1'b0, idx} + (FILL_W + 1)'(1)) == {1'b0, count});
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = B_CHECK;
        end
      end
      B_CHECK: begin
        if (cmd_op == OP_REG) begin
          if (fill < FILL_W'(PER_SLOT)) begin
            fill_we = 1'b1;
            ev_we   = 1'b1;
          end
          state_next = B_IDLE;
        end else begin
          fill_clr   = 1'b1;
          count_next = fill;
          idx_next   = '0;
          state_next = (fill == '0) ? B_IDLE : B_READ;
        end
      end
      B_READ: begin
        ev_re      = 1'b1;
        state_next = B_SEND;
      end
      B_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last) begin
            state_next = B_IDLE;
          end else begin
            idx_next   = idx + FILL_W'(1);
            state_next = B_READ;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      fill_valid <= '0;
    end else begin
      state <= state_next;
      if (fill_we) begin
        fill_valid[cmd_slot] <= 1'b1;
      end else if (fill_clr) begin
        fill_valid[cmd_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_op   <= q_op;
      cmd_slot <= q_slot;
      cmd_ev   <= q_ev;
      fill_rd  <= fill_mem[q_slot];
      fill_hit <= fill_valid[q_slot];
    end
    if (fill_we) begin
      fill_mem[cmd_slot] <= fill + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_mem[ev_waddr] <= cmd_ev;
    end
    if (ev_re) begin
      ev_rd <= ev_mem[ev_raddr];
      last  <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    count <= count_next;
    idx   <= idx_next;
  end

endmodule
